/* sv/i2c_master_command_engine_top_assert.svh */
// Assertion macros shared by the command engine modules.
`ifndef I2C_MASTER_COMMAND_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_COMMAND_ENGINE_TOP_ASSERT_SVH

// Checked on every edge outside reset.
`define I2C_MCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define I2C_MCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/i2c_mce_pkg.sv */
// Shared types and constants for the I2C master command engine.
package i2c_mce_pkg;

  localparam int READ_BYTES = 4;
  localparam int BYTE_IDX_W = 3;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(READ_BYTES - 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_PHASE_TICKS    = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd88;
  localparam logic [9:0] PHASE_TICKS_RST    = 10'd50;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_WBIT_LOW  = 4'd3,
    PH_WBIT_HIGH = 4'd4,
    PH_WACK_LOW  = 4'd5,
    PH_WACK_HIGH = 4'd6,
    PH_RBIT_LOW  = 4'd7,
    PH_RBIT_HIGH = 4'd8,
    PH_MACK_LOW  = 4'd9,
    PH_MACK_HIGH = 4'd10,
    PH_STOP_A    = 4'd11,
    PH_STOP_B    = 4'd12
  } phase_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] command;
    logic        sda;
  } q_entry_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [9:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [31:0] read_word;
    logic        nack_seen;
  } result_t;

endpackage

/* sv/i2c_mce_if.sv */
// Request and result channel interfaces of the command engine.
interface i2c_mce_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] cmd_high;
  logic [7:0] cmd_low;
  logic       sda_in;

  modport source (output valid, action, cmd_high, cmd_low, sda_in, input ready);
  modport sink   (input valid, action, cmd_high, cmd_low, sda_in, output ready);
endinterface

interface i2c_mce_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [31:0] read_word;
  logic        nack_seen;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_word,
                  nack_seen, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, read_word,
                  nack_seen, output ready);
endinterface

/* sv/i2c_master_command_engine_top.sv */
// Top level of the I2C master command engine: register port, front end, queue, sequencer.
//
// Usage: each request on in_ch is one tick of the bus clock base. action selects a plain
// tick, a write command (start, address+W, cmd_high, cmd_low, stop) or a four-byte read
// (start, address+R, four bytes MSB first, ACK on all but the last, stop). sda_in carries
// the sampled SDA level for that tick. Every request yields exactly one result on out_ch
// with the SCL level, the SDA pull-down, busy, a one-result done pulse, the word read so
// far and the NACK flag, all as they stand after that tick.
// Each bus phase lasts phase_ticks ticks (0 acts as 1); device_address sets the slave.
// Both registers sit at APB byte addresses 0 and 4; the user must write them only idle,
// which the block does not enforce. A request passes the queue, then the result register.
// Throughput: one request per cycle while out_ch.ready holds, set by the sequencer.
// Reset clears the sequencer, the four-entry queue and the result valid flag, and loads the
// register defaults (address 88, 50 ticks per phase).
// When the receiver stalls, the result holds, the sequencer stops, and in_ch.ready drops
// once four requests wait in the queue.
module i2c_master_command_engine_top (
  input  logic                             clk,
  input  logic                             rst,
  i2c_mce_in_if.sink                       in_ch,
  i2c_mce_out_if.source                    out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2c_mce_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  i2c_mce_pkg::cfg_t     cfg;
  i2c_mce_pkg::q_entry_t push_entry;
  i2c_mce_pkg::q_entry_t head_entry;
  logic q_push, q_pop, q_full, q_empty;
  logic reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= i2c_mce_pkg::DEVICE_ADDRESS_RST;
      cfg.phase_ticks    <= i2c_mce_pkg::PHASE_TICKS_RST;
    end else if (reg_wr) begin
      case (paddr[2])
        i2c_mce_pkg::REG_DEVICE_ADDRESS: cfg.device_address <= pwdata[6:0];
        i2c_mce_pkg::REG_PHASE_TICKS:    cfg.phase_ticks    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2c_mce_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, cfg.device_address};
      i2c_mce_pkg::REG_PHASE_TICKS:    prdata = {22'd0, cfg.phase_ticks};
      default:                         prdata = '0;
    endcase
  end

  i2c_mce_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  i2c_mce_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_entry),
    .pop     (q_pop),
    .rd_data (head_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  i2c_mce_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_entry (head_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* sv/i2c_mce_front.sv */
// Request front end: accepts requests, decodes the action and pushes queue entries.
module i2c_mce_front (
  i2c_mce_in_if.sink            in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output i2c_mce_pkg::q_entry_t q_entry
);

  i2c_mce_pkg::cmd_kind_t kind;

  // Unused action code falls through to a plain tick.
  always_comb begin
    case (in_ch.action)
      i2c_mce_pkg::ACT_WRITE: kind = i2c_mce_pkg::CMD_WRITE;
      i2c_mce_pkg::ACT_READ:  kind = i2c_mce_pkg::CMD_READ;
      default:                kind = i2c_mce_pkg::CMD_TICK;
    endcase
  end

  assign in_ch.ready     = ~q_full;
  assign q_push          = in_ch.valid & ~q_full;
  assign q_entry.kind    = kind;
  assign q_entry.command = {in_ch.cmd_high, in_ch.cmd_low};
  assign q_entry.sda     = in_ch.sda_in;

endmodule

/* sv/i2c_mce_fifo.sv */
// Short request queue between the front end and the bus sequencer.
`include "i2c_master_command_engine_top_assert.svh"

module i2c_mce_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  i2c_mce_pkg::q_entry_t wr_data,
  input  logic                  pop,
  output i2c_mce_pkg::q_entry_t rd_data,
  output logic                  full,
  output logic                  empty
);

  i2c_mce_pkg::q_entry_t mem [i2c_mce_pkg::QDEPTH];
  logic [i2c_mce_pkg::QPTR_W-1:0] wr_ptr;
  logic [i2c_mce_pkg::QPTR_W-1:0] rd_ptr;
  logic [i2c_mce_pkg::QCNT_W-1:0] count;

  localparam logic [i2c_mce_pkg::QPTR_W-1:0] PTR_LAST =
    i2c_mce_pkg::QPTR_W'(i2c_mce_pkg::QDEPTH - 1);
  localparam logic [i2c_mce_pkg::QCNT_W-1:0] CNT_FULL =
    i2c_mce_pkg::QCNT_W'(i2c_mce_pkg::QDEPTH);

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `I2C_MCE_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
  `I2C_MCE_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")
  `I2C_MCE_ASSERT_ALWAYS(a_count_range, rst || count <= CNT_FULL, "queue count out of range")

endmodule

/* sv/i2c_mce_seq.sv */
// Bus sequencer: runs one queued request per cycle while its result is taken, and registers it.
`include "i2c_master_command_engine_top_assert.svh"

module i2c_mce_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  i2c_mce_pkg::cfg_t     cfg,
  input  logic                  q_empty,
  input  i2c_mce_pkg::q_entry_t q_entry,
  output logic                  q_pop,
  i2c_mce_out_if.source         out_ch
);

  i2c_mce_pkg::phase_t phase, phase_next;
  logic [9:0]  tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [i2c_mce_pkg::BYTE_IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [31:0] gathered_word, gathered_word_next;
  logic        is_read, is_read_next;
  logic [15:0] saved_command, saved_command_next;
  logic        nack_flag, nack_flag_next;
  logic        done_next;

  i2c_mce_pkg::result_t res, res_next;
  logic res_valid;

  logic [9:0]  phase_len;
  logic [10:0] tick_inc;
  logic        tick_end;
  logic [3:0]  bit_inc;
  logic        master_ack;

  assign q_pop     = ~q_empty & (~res_valid | out_ch.ready);
  assign phase_len = (cfg.phase_ticks == '0) ? 10'd1 : cfg.phase_ticks;
  assign tick_inc  = {1'b0, tick_count} + 11'd1;
  assign tick_end  = (tick_inc >= {1'b0, phase_len});
  assign bit_inc   = bit_index + 4'd1;

  // Next state of the sequencer for the request at the head of the queue.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    shift_byte_next    = shift_byte;
    gathered_word_next = gathered_word;
    is_read_next       = is_read;
    saved_command_next = saved_command;
    nack_flag_next     = nack_flag;
    done_next          = 1'b0;
    if (phase == i2c_mce_pkg::PH_IDLE) begin
      if (q_entry.kind != i2c_mce_pkg::CMD_TICK) begin
        is_read_next       = (q_entry.kind == i2c_mce_pkg::CMD_READ);
        saved_command_next = q_entry.command;
        nack_flag_next     = 1'b0;
        if (q_entry.kind == i2c_mce_pkg::CMD_READ) begin
          gathered_word_next = '0;
        end
        tick_count_next = '0;
        bit_index_next  = '0;
        byte_index_next = '0;
        shift_byte_next = '0;
        phase_next      = i2c_mce_pkg::PH_START_A;
      end
    end else if (!tick_end) begin
      tick_count_next = tick_inc[9:0];
    end else begin
      tick_count_next = '0;
      case (phase)
        i2c_mce_pkg::PH_START_A: phase_next = i2c_mce_pkg::PH_START_B;
        i2c_mce_pkg::PH_START_B: begin
          shift_byte_next = {cfg.device_address, is_read};
          byte_index_next = '0;
          bit_index_next  = '0;
          phase_next      = i2c_mce_pkg::PH_WBIT_LOW;
        end
        i2c_mce_pkg::PH_WBIT_LOW: phase_next = i2c_mce_pkg::PH_WBIT_HIGH;
        i2c_mce_pkg::PH_WBIT_HIGH: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          phase_next      = bit_inc[3] ? i2c_mce_pkg::PH_WACK_LOW : i2c_mce_pkg::PH_WBIT_LOW;
        end
        i2c_mce_pkg::PH_WACK_LOW: phase_next = i2c_mce_pkg::PH_WACK_HIGH;
        i2c_mce_pkg::PH_WACK_HIGH: begin
          if (q_entry.sda) begin
            nack_flag_next = 1'b1;
          end
          bit_index_next = '0;
          if (is_read) begin
            byte_index_next = '0;
            shift_byte_next = '0;
            phase_next      = i2c_mce_pkg::PH_RBIT_LOW;
          end else begin
            byte_index_next = byte_index + 1'b1;
            if (byte_index == i2c_mce_pkg::BYTE_IDX_W'(0)) begin
              shift_byte_next = saved_command[15:8];
              phase_next      = i2c_mce_pkg::PH_WBIT_LOW;
            end else if (byte_index == i2c_mce_pkg::BYTE_IDX_W'(1)) begin
              shift_byte_next = saved_command[7:0];
              phase_next      = i2c_mce_pkg::PH_WBIT_LOW;
            end else begin
              phase_next = i2c_mce_pkg::PH_STOP_A;
            end
          end
        end
        i2c_mce_pkg::PH_RBIT_LOW: phase_next = i2c_mce_pkg::PH_RBIT_HIGH;
        i2c_mce_pkg::PH_RBIT_HIGH: begin
          shift_byte_next = {shift_byte[6:0], q_entry.sda};
          bit_index_next  = bit_inc;
          phase_next      = bit_inc[3] ? i2c_mce_pkg::PH_MACK_LOW : i2c_mce_pkg::PH_RBIT_LOW;
        end
        i2c_mce_pkg::PH_MACK_LOW: phase_next = i2c_mce_pkg::PH_MACK_HIGH;
        i2c_mce_pkg::PH_MACK_HIGH: begin
          gathered_word_next = {gathered_word[23:0], shift_byte};
          if (byte_index == i2c_mce_pkg::LAST_BYTE) begin
            phase_next = i2c_mce_pkg::PH_STOP_A;
          end else begin
            byte_index_next = byte_index + 1'b1;
            bit_index_next  = '0;
            shift_byte_next = '0;
            phase_next      = i2c_mce_pkg::PH_RBIT_LOW;
          end
        end
        i2c_mce_pkg::PH_STOP_A: phase_next = i2c_mce_pkg::PH_STOP_B;
        i2c_mce_pkg::PH_STOP_B: begin
          phase_next = i2c_mce_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        default: phase_next = i2c_mce_pkg::PH_IDLE;
      endcase
    end
  end

  // Pin levels and status as they stand after this request.
  assign master_ack = (byte_index_next != i2c_mce_pkg::LAST_BYTE);

  always_comb begin
    res_next.busy_res  = (phase_next != i2c_mce_pkg::PH_IDLE);
    res_next.done_res  = done_next;
    res_next.read_word = gathered_word_next;
    res_next.nack_seen = nack_flag_next;
    case (phase_next)
      i2c_mce_pkg::PH_START_A:   {res_next.scl_level, res_next.sda_pull_low} = 2'b11;
      i2c_mce_pkg::PH_START_B:   {res_next.scl_level, res_next.sda_pull_low} = 2'b01;
      i2c_mce_pkg::PH_WBIT_LOW:  {res_next.scl_level, res_next.sda_pull_low} =
                                   {1'b0, ~shift_byte_next[7]};
      i2c_mce_pkg::PH_WBIT_HIGH: {res_next.scl_level, res_next.sda_pull_low} =
                                   {1'b1, ~shift_byte_next[7]};
      i2c_mce_pkg::PH_WACK_LOW:  {res_next.scl_level, res_next.sda_pull_low} = 2'b00;
      i2c_mce_pkg::PH_WACK_HIGH: {res_next.scl_level, res_next.sda_pull_low} = 2'b10;
      i2c_mce_pkg::PH_RBIT_LOW:  {res_next.scl_level, res_next.sda_pull_low} = 2'b00;
      i2c_mce_pkg::PH_RBIT_HIGH: {res_next.scl_level, res_next.sda_pull_low} = 2'b10;
      i2c_mce_pkg::PH_MACK_LOW:  {res_next.scl_level, res_next.sda_pull_low} = {1'b0, master_ack};
      i2c_mce_pkg::PH_MACK_HIGH: {res_next.scl_level, res_next.sda_pull_low} = {1'b1, master_ack};
      i2c_mce_pkg::PH_STOP_A:    {res_next.scl_level, res_next.sda_pull_low} = 2'b01;
      i2c_mce_pkg::PH_STOP_B:    {res_next.scl_level, res_next.sda_pull_low} = 2'b11;
      default:                   {res_next.scl_level, res_next.sda_pull_low} = 2'b10;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2c_mce_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      byte_index    <= '0;
      shift_byte    <= '0;
      gathered_word <= '0;
      is_read       <= 1'b0;
      saved_command <= '0;
      nack_flag     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        byte_index    <= byte_index_next;
        shift_byte    <= shift_byte_next;
        gathered_word <= gathered_word_next;
        is_read       <= is_read_next;
        saved_command <= saved_command_next;
        nack_flag     <= nack_flag_next;
        res_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.scl_level    = res.scl_level;
  assign out_ch.sda_pull_low = res.sda_pull_low;
  assign out_ch.busy_res     = res.busy_res;
  assign out_ch.done_res     = res.done_res;
  assign out_ch.read_word    = res.read_word;
  assign out_ch.nack_seen    = res.nack_seen;

  `I2C_MCE_ASSERT(a_done_not_busy, res_valid && res.done_res |-> !res.busy_res,
                  "done reported while still busy")
  `I2C_MCE_ASSERT(a_busy_matches_phase,
                  res_valid |-> (res.busy_res == (phase != i2c_mce_pkg::PH_IDLE)),
                  "busy flag out of step with bus phase")
  `I2C_MCE_ASSERT(a_idle_tick_clear, phase == i2c_mce_pkg::PH_IDLE |-> tick_count == '0,
                  "tick counter running while idle")
  `I2C_MCE_ASSERT(a_bit_index_range, !bit_index[3] || bit_index[2:0] == 3'd0,
                  "bit index past eight")

endmodule
